/* hdl/motion_mask_bounding_box_assert.svh */
// ----------------------------------------------------------------------------
// Motion mask bounding box assertion macros
// Shorthand for the concurrent checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef MOTION_MASK_BOUNDING_BOX_ASSERT_SVH
`define MOTION_MASK_BOUNDING_BOX_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define MMBB_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("mmbb assertion failed");

// Next-cycle implication, checked out of reset.
`define MMBB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("mmbb assertion failed");

`endif

/* hdl/mmbb_pkg.sv */
// ----------------------------------------------------------------------------
// Motion mask bounding box package
// Shared widths, constants, register indexes and structs.
// ----------------------------------------------------------------------------
package mmbb_pkg;

    localparam int MAX_DIM   = 4096;
    localparam int DIM_W     = $clog2(MAX_DIM);
    localparam int FRAME_W   = DIM_W + 1;
    localparam int MARGIN_W  = 8;
    localparam int PIX_W     = 8;
    localparam int CNT_W     = 23;
    localparam int CFG_IDX_W = 2;

    localparam logic [PIX_W-1:0]    MARK_VALUE = 8'hFF;
    localparam logic [CNT_W-1:0]    CNT_MAX    = {CNT_W{1'b1}};
    localparam logic [FRAME_W-1:0]  DIM_LIMIT  = FRAME_W'(MAX_DIM);

    localparam logic [FRAME_W-1:0]  WIDTH_RST  = FRAME_W'(640);
    localparam logic [FRAME_W-1:0]  HEIGHT_RST = FRAME_W'(480);
    localparam logic [MARGIN_W-1:0] MARGIN_RST = MARGIN_W'(10);

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_MARGIN   = 2'd2;

    // Current raster position of the pixel in the input register.
    typedef struct packed {
        logic [DIM_W-1:0] col;
        logic [DIM_W-1:0] row;
        logic             sampled;
        logic             last_pix;
    } t_pos;

    // Box and count including the pixel now being retired.
    typedef struct packed {
        logic [DIM_W-1:0] min_col;
        logic [DIM_W-1:0] max_col;
        logic [DIM_W-1:0] min_row;
        logic [DIM_W-1:0] max_row;
        logic [CNT_W-1:0] count;
    } t_box;

    typedef struct packed {
        logic             found;
        logic [DIM_W-1:0] left_col;
        logic [DIM_W-1:0] right_col;
        logic [DIM_W-1:0] low_row;
        logic [DIM_W-1:0] high_row;
        logic [CNT_W-1:0] count;
    } t_result;

    // Last index of a dimension: zero counts as one, above MAX_DIM clamps.
    function automatic logic [DIM_W-1:0] last_index(input logic [FRAME_W-1:0] dim);
        logic [DIM_W-1:0] idx;
        if (dim == '0) begin
            idx = '0;
        end else if (dim > DIM_LIMIT) begin
            idx = {DIM_W{1'b1}};
        end else begin
            idx = DIM_W'(dim - FRAME_W'(1));
        end
        return idx;
    endfunction

endpackage

/* hdl/motion_mask_bounding_box.sv */
// ----------------------------------------------------------------------------
// Motion mask bounding box
// Finds the box around changed pixels of a raster-order motion mask frame.
// ----------------------------------------------------------------------------
// Feed one mask pixel per item in raster order; the block takes one pixel every
// clock while no frame-end pixel waits for the output register. An accepted pixel
// lands in an input register and is retired from there, where the raster counters
// advance and, if the pixel sits on even column and even row and equals 255, the
// box and change count widen. Retiring the last pixel of a frame loads one result
// into the output register, then clears the box and counters for the next frame.
// Every other pixel yields no result. Input ready drops only when a frame-end pixel
// waits for the output register to empty, so a stalled consumer costs no more than
// one held pixel. Frame size and margin must be written by the user through the
// plain write port while idle; the block itself does no check of this. A width or
// height of zero acts as one and sizes above 4096 clamp to 4096.
// ----------------------------------------------------------------------------
module motion_mask_bounding_box (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // configuration
    input  logic                               i_cfg_we,
    input  logic [mmbb_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [mmbb_pkg::FRAME_W-1:0]       i_cfg_data,
    // pixel input
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic [mmbb_pkg::PIX_W-1:0]         i_mask_pixel,
    // result output
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic                               o_motion_found,
    output logic [mmbb_pkg::DIM_W-1:0]         o_left_col,
    output logic [mmbb_pkg::DIM_W-1:0]         o_right_col,
    output logic [mmbb_pkg::DIM_W-1:0]         o_low_row,
    output logic [mmbb_pkg::DIM_W-1:0]         o_high_row,
    output logic [mmbb_pkg::CNT_W-1:0]         o_change_count
);

`include "motion_mask_bounding_box_assert.svh"

    // configuration registers
    logic [mmbb_pkg::FRAME_W-1:0]  r_frame_width;
    logic [mmbb_pkg::FRAME_W-1:0]  r_frame_height;
    logic [mmbb_pkg::MARGIN_W-1:0] r_box_margin;

    // input register
    logic                          r_in_valid;
    logic [mmbb_pkg::PIX_W-1:0]    r_pix;

    // output register
    logic                          r_out_valid;
    mmbb_pkg::t_result             r_result;

    logic [mmbb_pkg::DIM_W-1:0]    col_last;
    logic [mmbb_pkg::DIM_W-1:0]    row_last;
    logic                          out_free;
    logic                          advance;
    logic                          hit;
    mmbb_pkg::t_pos                pos;
    mmbb_pkg::t_box                box;
    mmbb_pkg::t_result             result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= mmbb_pkg::WIDTH_RST;
            r_frame_height <= mmbb_pkg::HEIGHT_RST;
            r_box_margin   <= mmbb_pkg::MARGIN_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                mmbb_pkg::REG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data;
                mmbb_pkg::REG_FRAME_HEIGHT: r_frame_height <= i_cfg_data;
                mmbb_pkg::REG_BOX_MARGIN:   r_box_margin   <= i_cfg_data[mmbb_pkg::MARGIN_W-1:0];
                default: ;
            endcase
        end
    end

    assign col_last = mmbb_pkg::last_index(r_frame_width);
    assign row_last = mmbb_pkg::last_index(r_frame_height);

    // Retire the held pixel unless it closes a frame and the result slot is busy.
    assign out_free   = ~r_out_valid | i_out_ready;
    assign advance    = r_in_valid & (~pos.last_pix | out_free);
    assign o_in_ready = ~r_in_valid | advance;
    assign hit        = pos.sampled & (r_pix == mmbb_pkg::MARK_VALUE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_pix <= i_mask_pixel;
        end
    end

    mmbb_raster_ctr u_raster_ctr (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_advance  (advance),
        .i_col_last (col_last),
        .i_row_last (row_last),
        .o_pos      (pos)
    );

    mmbb_box_acc u_box_acc (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_hit     (hit),
        .i_pos     (pos),
        .o_box     (box)
    );

    mmbb_margin u_margin (
        .i_box      (box),
        .i_margin   (r_box_margin),
        .i_col_last (col_last),
        .i_row_last (row_last),
        .o_result   (result)
    );

    // Load the result on the frame's last pixel; drop it once taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && pos.last_pix) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && pos.last_pix) begin
            r_result <= result;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_motion_found = r_result.found;
    assign o_left_col     = r_result.left_col;
    assign o_right_col    = r_result.right_col;
    assign o_low_row      = r_result.low_row;
    assign o_high_row     = r_result.high_row;
    assign o_change_count = r_result.count;

    // A frame result never overwrites one that has not been taken.
    `MMBB_ASSERT_NOW(a_no_overwrite, i_clk, i_rst_n, advance && pos.last_pix, out_free)
    // An empty frame reports a zero count, left column and high row.
    `MMBB_ASSERT_NOW(a_empty_zero, i_clk, i_rst_n, o_out_valid && !o_motion_found,
        o_change_count == '0 && o_left_col == '0 && o_high_row == '0)
    // A found box is never inverted.
    `MMBB_ASSERT_NOW(a_box_order, i_clk, i_rst_n, o_out_valid && o_motion_found,
        o_left_col <= o_right_col && o_low_row <= o_high_row && o_change_count != '0)
    // A held pixel that is not a frame end always retires.
    `MMBB_ASSERT_NEXT(a_stream_moves, i_clk, i_rst_n, r_in_valid && !pos.last_pix,
        o_in_ready || $past(advance))

endmodule

/* hdl/mmbb_raster_ctr.sv */
// ----------------------------------------------------------------------------
// Raster counter
// Column and row counters that follow the configured frame size.
// ----------------------------------------------------------------------------
module mmbb_raster_ctr (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_advance,
    input  logic [mmbb_pkg::DIM_W-1:0]     i_col_last,
    input  logic [mmbb_pkg::DIM_W-1:0]     i_row_last,
    output mmbb_pkg::t_pos                 o_pos
);

    logic [mmbb_pkg::DIM_W-1:0] r_col;
    logic [mmbb_pkg::DIM_W-1:0] r_row;
    logic [mmbb_pkg::DIM_W-1:0] n_col;
    logic [mmbb_pkg::DIM_W-1:0] n_row;
    logic                       last_col;
    logic                       last_row;

    // A counter past a shrunken size counts as sitting on the last index.
    assign last_col = (r_col >= i_col_last);
    assign last_row = (r_row >= i_row_last);

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (last_col && last_row) begin
            n_col = '0;
            n_row = '0;
        end else if (last_col) begin
            n_col = '0;
            n_row = r_row + mmbb_pkg::DIM_W'(1);
        end else begin
            n_col = r_col + mmbb_pkg::DIM_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (i_advance) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    assign o_pos.col      = r_col;
    assign o_pos.row      = r_row;
    assign o_pos.sampled  = ~r_col[0] & ~r_row[0];
    assign o_pos.last_pix = last_col & last_row;

endmodule

/* hdl/mmbb_box_acc.sv */
// ----------------------------------------------------------------------------
// Box accumulator
// Min/max column and row of marked sampled pixels plus a saturating count.
// ----------------------------------------------------------------------------
module mmbb_box_acc (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_advance,
    input  logic                       i_hit,
    input  mmbb_pkg::t_pos             i_pos,
    output mmbb_pkg::t_box             o_box
);

    mmbb_pkg::t_box r_box;
    mmbb_pkg::t_box n_box;

    // Empty box sits at min all ones and max zero, so the first hit needs no special case.
    always_comb begin
        n_box = r_box;
        if (i_hit) begin
            if (i_pos.col < r_box.min_col) n_box.min_col = i_pos.col;
            if (i_pos.col > r_box.max_col) n_box.max_col = i_pos.col;
            if (i_pos.row < r_box.min_row) n_box.min_row = i_pos.row;
            if (i_pos.row > r_box.max_row) n_box.max_row = i_pos.row;
            if (r_box.count != mmbb_pkg::CNT_MAX) begin
                n_box.count = r_box.count + mmbb_pkg::CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_box.min_col <= '1;
            r_box.max_col <= '0;
            r_box.min_row <= '1;
            r_box.max_row <= '0;
            r_box.count   <= '0;
        end else if (i_advance) begin
            if (i_pos.last_pix) begin
                r_box.min_col <= '1;
                r_box.max_col <= '0;
                r_box.min_row <= '1;
                r_box.max_row <= '0;
                r_box.count   <= '0;
            end else begin
                r_box <= n_box;
            end
        end
    end

    assign o_box = n_box;

endmodule

/* hdl/mmbb_margin.sv */
// ----------------------------------------------------------------------------
// Margin stage
// Widen each side of the finished box by the margin where it stays strictly inside the frame.
// ----------------------------------------------------------------------------
module mmbb_margin (
    input  mmbb_pkg::t_box                   i_box,
    input  logic [mmbb_pkg::MARGIN_W-1:0]    i_margin,
    input  logic [mmbb_pkg::DIM_W-1:0]       i_col_last,
    input  logic [mmbb_pkg::DIM_W-1:0]       i_row_last,
    output mmbb_pkg::t_result                o_result
);

    logic [mmbb_pkg::DIM_W-1:0] margin;
    logic [mmbb_pkg::DIM_W:0]   right_sum;
    logic [mmbb_pkg::DIM_W:0]   high_sum;
    logic                       found;

    assign margin    = mmbb_pkg::DIM_W'(i_margin);
    assign right_sum = {1'b0, i_box.max_col} + {1'b0, margin};
    assign high_sum  = {1'b0, i_box.max_row} + {1'b0, margin};
    assign found     = (i_box.count != '0);

    always_comb begin
        o_result = '0;
        if (found) begin
            o_result.found     = 1'b1;
            o_result.count     = i_box.count;
            o_result.left_col  = (i_box.min_col > margin) ? i_box.min_col - margin
                                                          : i_box.min_col;
            o_result.low_row   = (i_box.min_row > margin) ? i_box.min_row - margin
                                                          : i_box.min_row;
            o_result.right_col = (right_sum < {1'b0, i_col_last})
                               ? right_sum[mmbb_pkg::DIM_W-1:0] : i_box.max_col;
            o_result.high_row  = (high_sum < {1'b0, i_row_last})
                               ? high_sum[mmbb_pkg::DIM_W-1:0] : i_box.max_row;
        end
    end

endmodule
